[sv/fpw_pkg.sv]
// ----------------------------------------------------------------------------
// fpw_pkg
// types, codes and helpers shared by the framebuffer pixel writer
// ----------------------------------------------------------------------------
`default_nettype none

package fpw_pkg;

    // result status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_SKIPPED = 2'd1;
    localparam logic [1:0] STATUS_ERROR   = 2'd2;

    localparam int ADDR_W = 28;
    localparam int WORD_W = 32;

    // register indexes, one per 32-bit word of the register map
    typedef enum logic [2:0] {
        REG_SCREEN_WIDTH    = 3'd0,
        REG_SCREEN_HEIGHT   = 3'd1,
        REG_LINE_BYTES      = 3'd2,
        REG_PIXEL_DEPTH     = 3'd3,
        REG_RED_LAYOUT      = 3'd4,
        REG_GREEN_LAYOUT    = 3'd5,
        REG_BLUE_LAYOUT     = 3'd6,
        REG_DISPLAY_ENABLED = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [11:0] screen_width;
        logic [11:0] screen_height;
        logic [15:0] line_bytes;
        logic [5:0]  pixel_depth;
        logic [10:0] red_layout;
        logic [10:0] green_layout;
        logic [10:0] blue_layout;
        logic        display_enabled;
    } cfg_t;

    // stage 1: checked item with scaled channels
    typedef struct packed {
        logic [1:0]        status;
        logic [11:0]       x;
        logic [11:0]       y;
        logic [2:0]        bytes_pp;
        logic [WORD_W-1:0] red_field;
        logic [WORD_W-1:0] green_field;
        logic [WORD_W-1:0] blue_field;
    } s1_t;

    // stage 2: address partial terms and packed word
    typedef struct packed {
        logic [1:0]        status;
        logic [ADDR_W-1:0] row_offset;
        logic [14:0]       col_offset;
        logic [2:0]        bytes_pp;
        logic [WORD_W-1:0] pixel;
    } s2_t;

    // scale an 8-bit channel to a field of len bits, truncated to 32 bits
    function automatic logic [WORD_W-1:0] scale_channel(
        input logic [7:0] value,
        input logic [5:0] len
    );
        logic [38:0]       wide;
        logic [5:0]        sh;
        logic [WORD_W-1:0] res;
        wide = '0;
        sh   = len - 6'd8;
        if (len == 6'd0) begin
            res = '0;
        end else if (len >= 6'd8) begin
            if (sh > 6'd31) begin
                res = '0;
            end else begin
                wide = {31'd0, value} << sh[4:0];
                res  = wide[WORD_W-1:0];
            end
        end else begin
            res = {24'd0, value >> (4'd8 - {1'b0, len[2:0]})};
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[sv/fpw_regs.sv]
// ----------------------------------------------------------------------------
// fpw_regs
// apb register file holding the display layout configuration
// ----------------------------------------------------------------------------
`default_nettype none

module fpw_regs (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic      [31:0]  prdata,
    output logic              pready,
    output fpw_pkg::cfg_t     cfg
);
    import fpw_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.screen_width    <= 12'd800;
            cfg_reg.screen_height   <= 12'd480;
            cfg_reg.line_bytes      <= 16'd3200;
            cfg_reg.pixel_depth     <= 6'd32;
            cfg_reg.red_layout      <= 11'd272;
            cfg_reg.green_layout    <= 11'd264;
            cfg_reg.blue_layout     <= 11'd256;
            cfg_reg.display_enabled <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_SCREEN_WIDTH:    cfg_reg.screen_width    <= pwdata[11:0];
                REG_SCREEN_HEIGHT:   cfg_reg.screen_height   <= pwdata[11:0];
                REG_LINE_BYTES:      cfg_reg.line_bytes      <= pwdata[15:0];
                REG_PIXEL_DEPTH:     cfg_reg.pixel_depth     <= pwdata[5:0];
                REG_RED_LAYOUT:      cfg_reg.red_layout      <= pwdata[10:0];
                REG_GREEN_LAYOUT:    cfg_reg.green_layout    <= pwdata[10:0];
                REG_BLUE_LAYOUT:     cfg_reg.blue_layout     <= pwdata[10:0];
                REG_DISPLAY_ENABLED: cfg_reg.display_enabled <= pwdata[0];
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_SCREEN_WIDTH:    prdata = {20'd0, cfg_reg.screen_width};
            REG_SCREEN_HEIGHT:   prdata = {20'd0, cfg_reg.screen_height};
            REG_LINE_BYTES:      prdata = {16'd0, cfg_reg.line_bytes};
            REG_PIXEL_DEPTH:     prdata = {26'd0, cfg_reg.pixel_depth};
            REG_RED_LAYOUT:      prdata = {21'd0, cfg_reg.red_layout};
            REG_GREEN_LAYOUT:    prdata = {21'd0, cfg_reg.green_layout};
            REG_BLUE_LAYOUT:     prdata = {21'd0, cfg_reg.blue_layout};
            REG_DISPLAY_ENABLED: prdata = {31'd0, cfg_reg.display_enabled};
        endcase
    end

endmodule

`default_nettype wire

[sv/fpw_front.sv]
// ----------------------------------------------------------------------------
// fpw_front
// first stage: bounds and depth checks, channel scaling
// ----------------------------------------------------------------------------
`default_nettype none

module fpw_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                load,
    input  wire logic                in_valid,
    input  wire logic signed [15:0]  pos_x,
    input  wire logic signed [15:0]  pos_y,
    input  wire logic [7:0]          red_in,
    input  wire logic [7:0]          green_in,
    input  wire logic [7:0]          blue_in,
    input  wire fpw_pkg::cfg_t       cfg,
    output logic                     valid,
    output fpw_pkg::s1_t             stage
);
    import fpw_pkg::*;

    logic valid_reg;
    s1_t  stage_reg;
    s1_t  stage_next;
    logic coord_bad;
    logic depth_bad;

    // sign bit set means negative
    assign coord_bad = pos_x[15] | pos_y[15]
                     | (pos_x[14:0] >= {3'd0, cfg.screen_width})
                     | (pos_y[14:0] >= {3'd0, cfg.screen_height});
    assign depth_bad = (cfg.pixel_depth == 6'd0) | (cfg.pixel_depth > 6'd32);

    always_comb
    begin
        stage_next.x        = pos_x[11:0];
        stage_next.y        = pos_y[11:0];
        // ceil(bits / 8)
        stage_next.bytes_pp = cfg.pixel_depth[5:3] + {2'd0, |cfg.pixel_depth[2:0]};
        stage_next.red_field   = scale_channel(red_in,   cfg.red_layout[10:5]);
        stage_next.green_field = scale_channel(green_in, cfg.green_layout[10:5]);
        stage_next.blue_field  = scale_channel(blue_in,  cfg.blue_layout[10:5]);
        priority if (!cfg.display_enabled)
            stage_next.status = STATUS_SKIPPED;
        else if (coord_bad || depth_bad)
            stage_next.status = STATUS_ERROR;
        else
            stage_next.status = STATUS_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load && in_valid)
            stage_reg <= stage_next;
    end

    assign valid = valid_reg;
    assign stage = stage_reg;

endmodule

`default_nettype wire

[sv/fpw_mid.sv]
// ----------------------------------------------------------------------------
// fpw_mid
// second stage: address products and channel placement
// ----------------------------------------------------------------------------
`default_nettype none

module fpw_mid (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          load,
    input  wire logic          in_valid,
    input  wire fpw_pkg::s1_t  in_stage,
    input  wire fpw_pkg::cfg_t cfg,
    output logic               valid,
    output fpw_pkg::s2_t       stage
);
    import fpw_pkg::*;

    logic valid_reg;
    s2_t  stage_reg;
    s2_t  stage_next;

    always_comb
    begin
        stage_next.status     = in_stage.status;
        stage_next.bytes_pp   = in_stage.bytes_pp;
        stage_next.row_offset = {16'd0, in_stage.y} * {12'd0, cfg.line_bytes};
        stage_next.col_offset = {3'd0, in_stage.x} * {12'd0, in_stage.bytes_pp};
        stage_next.pixel      = (in_stage.red_field   << cfg.red_layout[4:0])
                              | (in_stage.green_field << cfg.green_layout[4:0])
                              | (in_stage.blue_field  << cfg.blue_layout[4:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load && in_valid)
            stage_reg <= stage_next;
    end

    assign valid = valid_reg;
    assign stage = stage_reg;

endmodule

`default_nettype wire

[sv/framebuffer_pixel_writer_top.sv]
// ----------------------------------------------------------------------------
// framebuffer_pixel_writer_top
// turns rgb888 pixel writes into packed framebuffer writes
// ----------------------------------------------------------------------------
//
//   channel   handshake                  payload
//   -------   -------------------------  ---------------------------------------
//   pixel     pixel_valid / pixel_ready  pos_x, pos_y, red_in, green_in, blue_in
//   write     write_valid / write_ready  status, write_address, pixel_word,
//                                        byte_count
//   config    apb psel/penable/pwrite    paddr, pwdata, prdata, pready
//
// one item per cycle sustained while write_ready stays high; write_valid rises
// once an accepted pixel has passed the three register stages
// stages: checks and scaling, address products and packing, address sum
// and output register
// rst_n clears the stage valid bits and loads the register reset values
// a stall on the write side holds every occupied stage; an empty stage
// still fills, so bubbles are squeezed out before pixel_ready drops
// ----------------------------------------------------------------------------
`default_nettype none

module framebuffer_pixel_writer_top (
    input  wire logic                clk,
    input  wire logic                rst_n,
    // pixel channel
    input  wire logic                pixel_valid,
    output logic                     pixel_ready,
    input  wire logic signed [15:0]  pos_x,
    input  wire logic signed [15:0]  pos_y,
    input  wire logic [7:0]          red_in,
    input  wire logic [7:0]          green_in,
    input  wire logic [7:0]          blue_in,
    // write channel
    output logic                     write_valid,
    input  wire logic                write_ready,
    output logic [1:0]               status,
    output logic [27:0]              write_address,
    output logic [31:0]              pixel_word,
    output logic [2:0]               byte_count,
    // configuration port
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [4:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);
    import fpw_pkg::*;

    cfg_t cfg;
    s1_t  s1;
    s2_t  s2;
    logic s1_valid;
    logic s2_valid;

    // stage load enables, back to front
    logic load3;
    logic load2;
    logic load1;

    // output register
    logic              out_valid_reg;
    logic [1:0]        status_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [WORD_W-1:0] word_reg;
    logic [2:0]        count_reg;
    logic [ADDR_W-1:0] addr_next;
    logic              ok;

    assign load3 = !out_valid_reg || write_ready;
    assign load2 = !s2_valid || load3;
    assign load1 = !s1_valid || load2;
    assign pixel_ready = load1;

    fpw_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fpw_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load1),
        .in_valid (pixel_valid),
        .pos_x    (pos_x),
        .pos_y    (pos_y),
        .red_in   (red_in),
        .green_in (green_in),
        .blue_in  (blue_in),
        .cfg      (cfg),
        .valid    (s1_valid),
        .stage    (s1)
    );

    fpw_mid u_mid (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load2),
        .in_valid (s1_valid),
        .in_stage (s1),
        .cfg      (cfg),
        .valid    (s2_valid),
        .stage    (s2)
    );

    // final address sum, wraps at 28 bits
    assign addr_next = s2.row_offset + {13'd0, s2.col_offset};
    assign ok        = (s2.status == STATUS_OK);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load3)
            out_valid_reg <= s2_valid;
    end

    // skipped and error writes carry zero payload
    always_ff @(posedge clk)
    begin
        if (load3 && s2_valid)
        begin
            status_reg <= s2.status;
            addr_reg   <= ok ? addr_next   : '0;
            word_reg   <= ok ? s2.pixel    : '0;
            count_reg  <= ok ? s2.bytes_pp : '0;
        end
    end

    assign write_valid   = out_valid_reg;
    assign status        = status_reg;
    assign write_address = addr_reg;
    assign pixel_word    = word_reg;
    assign byte_count    = count_reg;

endmodule

`default_nettype wire

[sv/fpw_checker.sv]
// ----------------------------------------------------------------------------
// fpw_checker
// port-level checks on the framebuffer pixel writer
// ----------------------------------------------------------------------------
`default_nettype none

module fpw_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        write_valid,
    input wire logic        write_ready,
    input wire logic [1:0]  status,
    input wire logic [27:0] write_address,
    input wire logic [31:0] pixel_word,
    input wire logic [2:0]  byte_count
);
    import fpw_pkg::*;

    // no item written out of order of reset: nothing shows valid right after it
    a_no_valid_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !write_valid)
        else $error("write valid right after reset");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        write_valid |-> (status == STATUS_OK || status == STATUS_SKIPPED
                         || status == STATUS_ERROR))
        else $error("unknown status code");

    a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (write_valid && status != STATUS_OK)
            |-> (write_address == 28'd0 && pixel_word == 32'd0 && byte_count == 3'd0))
        else $error("payload not cleared on skipped or error write");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (write_valid && status == STATUS_OK) |-> (byte_count != 3'd0 && byte_count <= 3'd4))
        else $error("byte count out of range");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (write_valid && !write_ready) |=>
            (write_valid && $stable(status) && $stable(write_address)
             && $stable(pixel_word) && $stable(byte_count)))
        else $error("write item changed while stalled");

endmodule

bind framebuffer_pixel_writer_top fpw_checker u_fpw_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .write_valid   (write_valid),
    .write_ready   (write_ready),
    .status        (status),
    .write_address (write_address),
    .pixel_word    (pixel_word),
    .byte_count    (byte_count)
);

`default_nettype wire

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the framebuffer pixel writer
//
// pixel writes go in on a valid/ready channel and every accepted item is
// run through a local predictor of the address, packing and error rules.
// The predicted framebuffer writes are queued and compared field by field
// against the write channel. Registers are rewritten over the apb port only
// while the pipe is drained. A short directed pass hits the corner cases,
// then random phases sweep register settings and idle/stall patterns.
// ----------------------------------------------------------------------------

module tb_top;

    import fpw_pkg::*;

    // run limit, far above the slowest legal run
    localparam int CYCLE_LIMIT = 600000;
    // pipe depth plus slack, used for the drain pause
    localparam int DRAIN_CYCLES = 6;

    // one expected framebuffer write
    typedef struct {
        logic [1:0]  status;
        logic [27:0] address;
        logic [31:0] word;
        logic [2:0]  count;
    } fb_write_t;

    logic               clk;
    logic               rst_n;
    logic               pixel_valid;
    logic               pixel_ready;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [7:0]         red_in;
    logic [7:0]         green_in;
    logic [7:0]         blue_in;
    logic               write_valid;
    logic               write_ready;
    logic [1:0]         status;
    logic [27:0]        write_address;
    logic [31:0]        pixel_word;
    logic [2:0]         byte_count;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [4:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    // shadow of the register file, kept in step with every apb write
    cfg_t      shadow_cfg;
    // framebuffer writes predicted but not yet seen on the write channel
    fb_write_t pending_writes[$];

    int mismatch_count;
    int cycle_count;
    int sender_idle_pct;
    int receiver_stall_pct;

    framebuffer_pixel_writer_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .pixel_valid   (pixel_valid),
        .pixel_ready   (pixel_ready),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .red_in        (red_in),
        .green_in      (green_in),
        .blue_in       (blue_in),
        .write_valid   (write_valid),
        .write_ready   (write_ready),
        .status        (status),
        .write_address (write_address),
        .pixel_word    (pixel_word),
        .byte_count    (byte_count),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // ------------------------------------------------------------------------
    // clock and run limit
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // hard stop in case the handshake hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // scale one 8-bit channel to its field length and move it to its offset;
    // anything above bit 31 falls off
    function automatic logic [31:0] pack_channel(input logic [7:0] value,
                                                 input logic [10:0] layout);
        logic [4:0]  offset;
        logic [5:0]  len;
        logic [63:0] field;
        offset = layout[4:0];
        len    = layout[10:5];
        if (len == 6'd0)
            field = 64'd0;
        else if (len >= 6'd8)
            field = ({56'd0, value} << (len - 6'd8)) & 64'hFFFF_FFFF;
        else
            field = {56'd0, value} >> (8 - int'(len));
        field = field << offset;
        return field[31:0];
    endfunction

    // expected framebuffer write for one pixel under the shadow registers
    function automatic fb_write_t predict_fb_write(input logic [15:0] x,
                                                   input logic [15:0] y,
                                                   input logic [7:0] r,
                                                   input logic [7:0] g,
                                                   input logic [7:0] b);
        fb_write_t   wr;
        logic [63:0] bytes_pp;
        logic [63:0] addr;
        wr.status  = STATUS_SKIPPED;
        wr.address = '0;
        wr.word    = '0;
        wr.count   = '0;
        // disabled display wins over every error check
        if (!shadow_cfg.display_enabled)
            return wr;
        wr.status = STATUS_ERROR;
        if (x[15] || y[15])
            return wr;
        if (x >= {4'd0, shadow_cfg.screen_width} || y >= {4'd0, shadow_cfg.screen_height})
            return wr;
        if (shadow_cfg.pixel_depth == 6'd0 || shadow_cfg.pixel_depth > 6'd32)
            return wr;
        bytes_pp   = (64'(shadow_cfg.pixel_depth) + 64'd7) / 64'd8;
        addr       = 64'(y) * 64'(shadow_cfg.line_bytes) + 64'(x) * bytes_pp;
        wr.status  = STATUS_OK;
        wr.address = addr[27:0];
        wr.word    = pack_channel(r, shadow_cfg.red_layout)
                   | pack_channel(g, shadow_cfg.green_layout)
                   | pack_channel(b, shadow_cfg.blue_layout);
        wr.count   = bytes_pp[2:0];
        return wr;
    endfunction

    // ------------------------------------------------------------------------
    // write channel: random backpressure and result checking
    // ------------------------------------------------------------------------

    // ready is redrawn every cycle from the current stall rate
    always @(negedge clk)
    begin
        write_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    // every accepted write is matched against the oldest prediction
    always @(posedge clk)
    begin
        fb_write_t exp_wr;
        if (rst_n && write_valid && write_ready)
        begin
            if (pending_writes.size() == 0)
            begin
                $error("write item with nothing expected: status %0d addr 0x%07h word 0x%08h",
                       status, write_address, pixel_word);
                mismatch_count++;
            end
            else
            begin
                exp_wr = pending_writes.pop_front();
                if (status !== exp_wr.status)
                begin
                    $error("status: expected %0d, got %0d", exp_wr.status, status);
                    mismatch_count++;
                end
                if (write_address !== exp_wr.address)
                begin
                    $error("write_address: expected 0x%07h, got 0x%07h",
                           exp_wr.address, write_address);
                    mismatch_count++;
                end
                if (pixel_word !== exp_wr.word)
                begin
                    $error("pixel_word: expected 0x%08h, got 0x%08h", exp_wr.word, pixel_word);
                    mismatch_count++;
                end
                if (byte_count !== exp_wr.count)
                begin
                    $error("byte_count: expected %0d, got %0d", exp_wr.count, byte_count);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // pixel channel and apb helpers
    // ------------------------------------------------------------------------

    // offer one pixel item, with random idle cycles in front of it, and
    // queue its prediction once it is taken; valid stays high on return
    task automatic send_pixel(input logic [15:0] x, input logic [15:0] y,
                              input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b);
        @(negedge clk);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            pixel_valid <= 1'b0;
            @(negedge clk);
        end
        pixel_valid <= 1'b1;
        pos_x       <= x;
        pos_y       <= y;
        red_in      <= r;
        green_in    <= g;
        blue_in     <= b;
        do
            @(posedge clk);
        while (!pixel_ready);
        pending_writes.push_back(predict_fb_write(x, y, r, g, b));
    endtask

    // drop valid and let the pipe empty out before touching registers
    task automatic drain_pipe();
        @(negedge clk);
        pixel_valid <= 1'b0;
        while (pending_writes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // apb write: setup cycle, then access cycle until pready; bits above the
    // register width carry junk, the register must ignore them
    task automatic write_register(input reg_idx_t idx, input logic [31:0] value);
        logic [31:0] mask;
        case (idx)
            REG_SCREEN_WIDTH:    mask = 32'h0000_0FFF;
            REG_SCREEN_HEIGHT:   mask = 32'h0000_0FFF;
            REG_LINE_BYTES:      mask = 32'h0000_FFFF;
            REG_PIXEL_DEPTH:     mask = 32'h0000_003F;
            REG_RED_LAYOUT:      mask = 32'h0000_07FF;
            REG_GREEN_LAYOUT:    mask = 32'h0000_07FF;
            REG_BLUE_LAYOUT:     mask = 32'h0000_07FF;
            default:             mask = 32'h0000_0001;
        endcase
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= (value & mask) | ($urandom & ~mask);
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_SCREEN_WIDTH:    shadow_cfg.screen_width    = value[11:0];
            REG_SCREEN_HEIGHT:   shadow_cfg.screen_height   = value[11:0];
            REG_LINE_BYTES:      shadow_cfg.line_bytes      = value[15:0];
            REG_PIXEL_DEPTH:     shadow_cfg.pixel_depth     = value[5:0];
            REG_RED_LAYOUT:      shadow_cfg.red_layout      = value[10:0];
            REG_GREEN_LAYOUT:    shadow_cfg.green_layout    = value[10:0];
            REG_BLUE_LAYOUT:     shadow_cfg.blue_layout     = value[10:0];
            default:             shadow_cfg.display_enabled = value[0];
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // whole register file in one go, enable last
    task automatic load_config(input logic [11:0] width, input logic [11:0] height,
                               input logic [15:0] line, input logic [5:0] bpp,
                               input logic [10:0] red_lay, input logic [10:0] green_lay,
                               input logic [10:0] blue_lay, input logic enable);
        write_register(REG_SCREEN_WIDTH, 32'(width));
        write_register(REG_SCREEN_HEIGHT, 32'(height));
        write_register(REG_LINE_BYTES, 32'(line));
        write_register(REG_PIXEL_DEPTH, 32'(bpp));
        write_register(REG_RED_LAYOUT, 32'(red_lay));
        write_register(REG_GREEN_LAYOUT, 32'(green_lay));
        write_register(REG_BLUE_LAYOUT, 32'(blue_lay));
        write_register(REG_DISPLAY_ENABLED, 32'(enable));
    endtask

    // layout word: length in bits 10:5, offset in bits 4:0
    function automatic logic [10:0] layout_of(input int len, input int offset);
        return {6'(len), 5'(offset)};
    endfunction

    // one random pixel, mostly on screen so the packing path gets exercised
    task automatic send_random_pixel();
        int          pick;
        logic [15:0] x;
        logic [15:0] y;
        logic [7:0]  rgb[3];
        pick = $urandom_range(0, 99);
        x = 16'($urandom_range(0, shadow_cfg.screen_width == 0 ? 0 : shadow_cfg.screen_width - 1));
        y = 16'($urandom_range(0, shadow_cfg.screen_height == 0 ? 0 :
                                   shadow_cfg.screen_height - 1));
        // right and bottom edge now and then
        if ($urandom_range(0, 9) == 0 && shadow_cfg.screen_width != 0)
            x = 16'(shadow_cfg.screen_width - 1);
        if ($urandom_range(0, 9) == 0 && shadow_cfg.screen_height != 0)
            y = 16'(shadow_cfg.screen_height - 1);
        if (pick >= 75 && pick < 83)
        begin
            // off screen, either axis
            if ($urandom_range(0, 1))
                x = 16'($urandom_range(shadow_cfg.screen_width, 32767));
            else
                y = 16'($urandom_range(shadow_cfg.screen_height, 32767));
        end
        else if (pick >= 83 && pick < 90)
        begin
            // negative coordinate
            if ($urandom_range(0, 1))
                x = 16'($urandom_range(32768, 65535));
            else
                y = 16'($urandom_range(32768, 65535));
        end
        else if (pick >= 90)
        begin
            // anything the port can carry
            x = 16'($urandom);
            y = 16'($urandom);
        end
        foreach (rgb[i])
        begin
            case ($urandom_range(0, 7))
                0:       rgb[i] = 8'h00;
                1:       rgb[i] = 8'hFF;
                default: rgb[i] = 8'($urandom);
            endcase
        end
        send_pixel(x, y, rgb[0], rgb[1], rgb[2]);
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // out of reset the display is off, so every item must come back skipped
    task automatic test_reset_disabled();
        send_pixel(16'd0, 16'd0, 8'h00, 8'h00, 8'h00);
        send_pixel(16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
        drain_pipe();
    endtask

    // bounds checks on the default 800x480 rgb888 layout
    task automatic test_bounds();
        write_register(REG_DISPLAY_ENABLED, 32'd1);
        send_pixel(16'd0, 16'd0, 8'hFF, 8'h00, 8'h00);
        send_pixel(16'd799, 16'd479, 8'h00, 8'hFF, 8'h00);
        // one past the right edge and one past the bottom edge
        send_pixel(16'd800, 16'd0, 8'h00, 8'h00, 8'hFF);
        send_pixel(16'd0, 16'd480, 8'h12, 8'h34, 8'h56);
        // most negative x, minus one y, largest positive both
        send_pixel(16'h8000, 16'd0, 8'hFF, 8'hFF, 8'hFF);
        send_pixel(16'd0, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
        send_pixel(16'h7FFF, 16'h7FFF, 8'hAA, 8'h55, 8'hA5);
        drain_pipe();
    endtask

    // depth of zero and over thirty-two is an error, small depths give one byte
    task automatic test_pixel_depth();
        write_register(REG_PIXEL_DEPTH, 32'd0);
        send_pixel(16'd1, 16'd1, 8'h80, 8'h80, 8'h80);
        drain_pipe();
        write_register(REG_PIXEL_DEPTH, 32'd33);
        send_pixel(16'd1, 16'd1, 8'h80, 8'h80, 8'h80);
        drain_pipe();
        write_register(REG_PIXEL_DEPTH, 32'd1);
        send_pixel(16'd5, 16'd2, 8'hFF, 8'h01, 8'h7F);
        drain_pipe();
        write_register(REG_PIXEL_DEPTH, 32'd24);
        send_pixel(16'd9, 16'd3, 8'h11, 8'h22, 8'h33);
        drain_pipe();
    endtask

    // long fields, zero-length fields and fields running past bit 31
    task automatic test_layouts();
        write_register(REG_PIXEL_DEPTH, 32'd32);
        write_register(REG_RED_LAYOUT, 32'(layout_of(32, 0)));
        write_register(REG_GREEN_LAYOUT, 32'(layout_of(63, 0)));
        write_register(REG_BLUE_LAYOUT, 32'(layout_of(4, 30)));
        send_pixel(16'd3, 16'd3, 8'hFF, 8'hFF, 8'hFF);
        drain_pipe();
        write_register(REG_RED_LAYOUT, 32'(layout_of(8, 31)));
        write_register(REG_GREEN_LAYOUT, 32'(layout_of(0, 7)));
        write_register(REG_BLUE_LAYOUT, 32'(layout_of(1, 0)));
        send_pixel(16'd4, 16'd0, 8'hFF, 8'hC3, 8'h80);
        send_pixel(16'd4, 16'd0, 8'h7F, 8'hC3, 8'h7F);
        drain_pipe();
        write_register(REG_RED_LAYOUT, 32'(layout_of(7, 20)));
        write_register(REG_GREEN_LAYOUT, 32'(layout_of(12, 24)));
        write_register(REG_BLUE_LAYOUT, 32'(layout_of(39, 0)));
        send_pixel(16'd6, 16'd6, 8'hB7, 8'hE9, 8'h01);
        drain_pipe();
    endtask

    // largest screen and stride: the address comes close to 2^28 but stays below it
    task automatic test_address_wrap();
        load_config(12'd4095, 12'd4095, 16'hFFFF, 6'd32, layout_of(8, 16), layout_of(8, 8),
                    layout_of(8, 0), 1'b1);
        send_pixel(16'd4095, 16'd4095, 8'h01, 8'h02, 8'h03);
        send_pixel(16'd0, 16'd4095, 8'hFE, 8'hFD, 8'hFC);
        drain_pipe();
    endtask

    // random phases: each one loads a register setting and an idle pattern
    task automatic test_random_phases();
        int item_total;
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                // plain rgb888
                0: load_config(12'd800, 12'd480, 16'd3200, 6'd32, layout_of(8, 16),
                               layout_of(8, 8), layout_of(8, 0), 1'b1);
                // everything at its top value except a legal depth
                1: load_config(12'd4095, 12'd4095, 16'hFFFF, 6'd32, 11'h7FF, 11'h7FF,
                               11'h7FF, 1'b1);
                // one-pixel screen, zero stride, one-bit depth, empty fields
                2: load_config(12'd1, 12'd1, 16'd0, 6'd1, 11'd0, 11'd0, 11'd0, 1'b1);
                // rgb565
                3: load_config(12'd320, 12'd240, 16'd640, 6'd16, layout_of(5, 11),
                               layout_of(6, 5), layout_of(5, 0), 1'b1);
                // fully random registers, depth may be illegal
                4: load_config(12'($urandom_range(1, 4095)), 12'($urandom_range(1, 4095)),
                               16'($urandom), 6'($urandom_range(0, 40)), 11'($urandom),
                               11'($urandom), 11'($urandom), 1'b1);
                // display off with a random setting behind it
                5: load_config(12'($urandom), 12'($urandom), 16'($urandom), 6'($urandom),
                               11'($urandom), 11'($urandom), 11'($urandom), 1'b0);
                // random but legal depth and field lengths
                6: load_config(12'($urandom_range(1, 2048)), 12'($urandom_range(1, 2048)),
                               16'($urandom), 6'($urandom_range(1, 32)),
                               layout_of($urandom_range(0, 32), $urandom_range(0, 31)),
                               layout_of($urandom_range(0, 32), $urandom_range(0, 31)),
                               layout_of($urandom_range(0, 32), $urandom_range(0, 31)),
                               1'b1);
                // zero-sized screen, everything is out of bounds
                default: load_config(12'd0, 12'd0, 16'd100, 6'd8, layout_of(3, 5),
                                     layout_of(3, 2), layout_of(2, 0), 1'b1);
            endcase
            // cycle through: no idling, slow sender, slow receiver, light on both
            case (phase % 4)
                0:       begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1:       begin sender_idle_pct = 72; receiver_stall_pct = 0;  end
                2:       begin sender_idle_pct = 0;  receiver_stall_pct = 72; end
                default: begin sender_idle_pct = 7;  receiver_stall_pct = 7;  end
            endcase
            if (phase == 5)
                item_total = 150;
            else if (phase == 7)
                item_total = 60;
            else
                item_total = 290;
            repeat (item_total) send_random_pixel();
            drain_pipe();
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        // every input known from time zero
        rst_n              = 1'b0;
        pixel_valid        = 1'b0;
        pos_x              = '0;
        pos_y              = '0;
        red_in             = '0;
        green_in           = '0;
        blue_in            = '0;
        write_ready        = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        mismatch_count     = 0;
        cycle_count        = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        // register values after reset
        shadow_cfg.screen_width    = 12'd800;
        shadow_cfg.screen_height   = 12'd480;
        shadow_cfg.line_bytes      = 16'd3200;
        shadow_cfg.pixel_depth     = 6'd32;
        shadow_cfg.red_layout      = 11'd272;
        shadow_cfg.green_layout    = 11'd264;
        shadow_cfg.blue_layout     = 11'd256;
        shadow_cfg.display_enabled = 1'b0;

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        test_reset_disabled();
        test_bounds();
        test_pixel_depth();
        test_layouts();
        test_address_wrap();
        test_random_phases();

        drain_pipe();
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
